// ===== src/dtwgtc_pkg.sv =====
// ----------------------------------------------------------------------------
// dtwgtc_pkg
// Shared constants and controller/datapath interface types of the DTW
// template classifier.
// ----------------------------------------------------------------------------
package dtwgtc_pkg;

  localparam int TEMPLATE_COUNT   = 8;
  localparam int TEMPLATE_MAX_LEN = 64;
  localparam int GESTURE_MAX_LEN  = 255;
  localparam int SAMPLE_WIDTH     = 8;

  localparam int STORE_DEPTH = TEMPLATE_COUNT * TEMPLATE_MAX_LEN;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int T_W         = $clog2(TEMPLATE_COUNT);
  localparam int TCNT_W      = $clog2(TEMPLATE_COUNT + 1);
  localparam int J_W         = $clog2(TEMPLATE_MAX_LEN);
  localparam int LEN_W       = $clog2(TEMPLATE_MAX_LEN + 1);
  localparam int GC_W        = $clog2(GESTURE_MAX_LEN + 1);
  localparam int DIV_W       = $clog2(GESTURE_MAX_LEN + TEMPLATE_MAX_LEN + 1);
  localparam int CELL_W      = 32;
  localparam int LC_W        = 2 * (SAMPLE_WIDTH + 1) + 2;
  localparam int CFG_W       = 4;
  localparam int IDX_W       = 3;
  localparam int DIST_W      = 27;
  localparam int TSW_W       = 3 * SAMPLE_WIDTH;

  localparam logic [CELL_W-1:0] EMPTY_SCORE = CELL_W'(100000000);

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_GESTURE = 1'b1;

  typedef struct packed {
    logic           capture;
    logic           load_do;
    logic           row_issue;
    logic           gc_step;
    logic           cls_rd;
    logic           div_start;
    logic           cls_take;
    logic           out_fire;
    logic [T_W-1:0] t;
    logic [J_W-1:0] j;
  } cmd_t;

  typedef struct packed {
    logic              op;
    logic              last;
    logic              gc_full;
    logic              pipe_busy;
    logic              div_done;
    logic [LEN_W-1:0]  cur_len;
    logic [TCNT_W-1:0] n_active;
  } sts_t;

endpackage

// ===== src/dtw_gesture_template_classifier.sv =====
// ----------------------------------------------------------------------------
// dtw_gesture_template_classifier
// Nearest-template gesture classifier using dynamic time warping.
// ----------------------------------------------------------------------------
// A word is accepted when start is high and busy is low; busy stays high until
// the word is fully processed. A template load is written from the dispatch
// state, which then returns to idle. A gesture sample sweeps the cells of each
// active template slot in turn and skips an empty slot. The sweep is paced by
// the single read port of the cost memory feeding the cell pipeline. A dropped
// sample past the gesture limit skips the sweep. A last gesture sample also
// runs the bit-serial normalizing divider once per active slot.
// result_valid_o then pulses for one cycle as busy falls; results cannot be
// stalled. Configuration writes are always ready and take effect at once.
module dtw_gesture_template_classifier (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        start,
  output logic                                        busy,
  input  logic                                        cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  logic [dtwgtc_pkg::CFG_W-1:0]                cfg_data_i,
  input  logic                                        op_i,
  input  logic [2:0]                                  template_slot_i,
  input  logic signed [dtwgtc_pkg::SAMPLE_WIDTH-1:0]  accel_x_i,
  input  logic signed [dtwgtc_pkg::SAMPLE_WIDTH-1:0]  accel_y_i,
  input  logic signed [dtwgtc_pkg::SAMPLE_WIDTH-1:0]  accel_z_i,
  input  logic                                        last_sample_i,
  output logic                                        result_valid_o,
  output logic [dtwgtc_pkg::IDX_W-1:0]                match_index_o,
  output logic [dtwgtc_pkg::DIST_W-1:0]               match_distance_o
);

  dtwgtc_pkg::cmd_t cmd;
  dtwgtc_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  dtwgtc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  dtwgtc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .op_i             (op_i),
    .template_slot_i  (template_slot_i),
    .accel_x_i        (accel_x_i),
    .accel_y_i        (accel_y_i),
    .accel_z_i        (accel_z_i),
    .last_sample_i    (last_sample_i),
    .result_valid_o   (result_valid_o),
    .match_index_o    (match_index_o),
    .match_distance_o (match_distance_o)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("busy not raised after accept");
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe longer than one cycle");
  a_row_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.row_issue |=> sts.pipe_busy) else $error("cell pipeline lost an issue");
  a_div_idle_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.row_issue |-> !cmd.div_start) else $error("row sweep overlaps divide");
`endif

endmodule

// ===== src/dtwgtc_ram.sv =====
// ----------------------------------------------------------------------------
// dtwgtc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dtwgtc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/dtwgtc_div.sv =====
// ----------------------------------------------------------------------------
// dtwgtc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dtwgtc_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [dtwgtc_pkg::CELL_W-1:0]    dividend_i,
  input  logic [dtwgtc_pkg::DIV_W-1:0]     divisor_i,
  output logic                             done_o,
  output logic [dtwgtc_pkg::CELL_W-1:0]    quot_o
);

  localparam int CNT_W = $clog2(dtwgtc_pkg::CELL_W + 1);

  logic                           run_q, run_d;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic [dtwgtc_pkg::DIV_W-1:0]   rem_q, rem_d;
  logic [dtwgtc_pkg::DIV_W-1:0]   dvs_q, dvs_d;
  logic [dtwgtc_pkg::CELL_W-1:0]  quo_q, quo_d;
  logic                           done_q, done_d;
  logic [dtwgtc_pkg::DIV_W:0]     trial;
  logic                           qbit;

  always_comb begin
    trial  = {rem_q, quo_q[dtwgtc_pkg::CELL_W-1]};
    qbit   = (trial >= {1'b0, dvs_q});
    run_d  = run_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    done_d = 1'b0;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      dvs_d = divisor_i;
      quo_d = dividend_i;
    end else if (run_q) begin
      rem_d = qbit ? dtwgtc_pkg::DIV_W'(trial - {1'b0, dvs_q})
                   : trial[dtwgtc_pkg::DIV_W-1:0];
      quo_d = {quo_q[dtwgtc_pkg::CELL_W-2:0], qbit};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(dtwgtc_pkg::CELL_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== src/dtwgtc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtwgtc_ctrl
// Sequencer: template loads, DTW row sweep over slots, classification loop.
// ----------------------------------------------------------------------------
module dtwgtc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  dtwgtc_pkg::sts_t   sts_i,
  output dtwgtc_pkg::cmd_t   cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DISP   = 8'b0000_0010,
    S_RUN    = 8'b0000_0100,
    S_ROWEND = 8'b0000_1000,
    S_CRD    = 8'b0001_0000,
    S_CSTART = 8'b0010_0000,
    S_CWAIT  = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_e;

  state_e                             state_q, state_d;
  logic [dtwgtc_pkg::TCNT_W-1:0]      t_q, t_d;
  logic [dtwgtc_pkg::LEN_W-1:0]       j_q, j_d;

  always_comb begin
    state_d = state_q;
    t_d     = t_q;
    j_d     = j_q;
    cmd_o   = '0;
    cmd_o.t = t_q[dtwgtc_pkg::T_W-1:0];
    cmd_o.j = j_q[dtwgtc_pkg::J_W-1:0];
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.op == dtwgtc_pkg::OP_LOAD) begin
          cmd_o.load_do = 1'b1;
          state_d       = S_IDLE;
        end else if (sts_i.gc_full) begin
          state_d = S_ROWEND;
        end else begin
          t_d     = '0;
          j_d     = '0;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (t_q >= sts_i.n_active) begin
          state_d = S_ROWEND;
        end else if (j_q < sts_i.cur_len) begin
          cmd_o.row_issue = 1'b1;
          j_d             = j_q + dtwgtc_pkg::LEN_W'(1);
        end else if (!sts_i.pipe_busy) begin
          t_d = t_q + dtwgtc_pkg::TCNT_W'(1);
          j_d = '0;
        end
      end
      S_ROWEND: begin
        cmd_o.gc_step = 1'b1;
        t_d           = '0;
        state_d       = sts_i.last ? S_CRD : S_IDLE;
      end
      S_CRD: begin
        cmd_o.cls_rd = 1'b1;
        state_d      = S_CSTART;
      end
      S_CSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_CWAIT;
      end
      S_CWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.cls_take = 1'b1;
          if (t_q + dtwgtc_pkg::TCNT_W'(1) < sts_i.n_active) begin
            t_d     = t_q + dtwgtc_pkg::TCNT_W'(1);
            state_d = S_CRD;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        cmd_o.out_fire = 1'b1;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      t_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      t_q     <= t_d;
      j_q     <= j_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ===== src/dtwgtc_dp.sv =====
// ----------------------------------------------------------------------------
// dtwgtc_dp
// Datapath: template and cost memories, DTW cell pipeline, normalization
// and minimum search.
// ----------------------------------------------------------------------------
module dtwgtc_dp (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  dtwgtc_pkg::cmd_t                        cmd_i,
  output dtwgtc_pkg::sts_t                        sts_o,
  input  logic                                    cfg_we_i,
  input  logic [dtwgtc_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                    op_i,
  input  logic [2:0]                              template_slot_i,
  input  logic signed [dtwgtc_pkg::SAMPLE_WIDTH-1:0] accel_x_i,
  input  logic signed [dtwgtc_pkg::SAMPLE_WIDTH-1:0] accel_y_i,
  input  logic signed [dtwgtc_pkg::SAMPLE_WIDTH-1:0] accel_z_i,
  input  logic                                    last_sample_i,
  output logic                                    result_valid_o,
  output logic [dtwgtc_pkg::IDX_W-1:0]            match_index_o,
  output logic [dtwgtc_pkg::DIST_W-1:0]           match_distance_o
);

  localparam int SW  = dtwgtc_pkg::SAMPLE_WIDTH;
  localparam int AW  = dtwgtc_pkg::ADDR_W;
  localparam int CW  = dtwgtc_pkg::CELL_W;
  localparam int LW  = dtwgtc_pkg::LEN_W;

  logic [dtwgtc_pkg::CFG_W-1:0]   tiu_q;
  logic [dtwgtc_pkg::TCNT_W-1:0]  n_active;
  logic [LW-1:0]                  len_q [dtwgtc_pkg::TEMPLATE_COUNT];
  logic [LW-1:0]                  lp_q;
  logic [dtwgtc_pkg::GC_W-1:0]    gc_q;

  logic                           op_q, last_q;
  logic [2:0]                     slot_q;
  logic signed [SW-1:0]           gx_q, gy_q, gz_q;

  logic                           t_we;
  logic [AW-1:0]                  t_waddr;
  logic [dtwgtc_pkg::TSW_W-1:0]   t_rdata;
  logic                           c_we;
  logic [AW-1:0]                  c_raddr;
  logic [CW-1:0]                  c_rdata;
  logic [AW-1:0]                  row_addr;
  logic [AW-1:0]                  base_addr;
  logic [LW-1:0]                  cur_len;

  logic                           s1_v_q, s1_first_q;
  logic [AW-1:0]                  s1_addr_q;
  logic                           s2_v_q, s2_first_q;
  logic [AW-1:0]                  s2_addr_q;
  logic [dtwgtc_pkg::LC_W-1:0]    s2_lc_q;
  logic [CW-1:0]                  s2_up_q;
  logic [CW-1:0]                  left_q, diag_q;

  logic signed [SW:0]             dx, dy, dz;
  logic [2*SW+1:0]                sqx, sqy, sqz;
  logic [dtwgtc_pkg::LC_W-1:0]    lc;
  logic [CW-1:0]                  prior, m1, cell_val;
  logic [CW:0]                    cell_sum;
  logic                           row0;

  logic [dtwgtc_pkg::GC_W-1:0]    glen;
  logic [CW-1:0]                  dividend;
  logic [dtwgtc_pkg::DIV_W-1:0]   divisor;
  logic                           div_done;
  logic [CW-1:0]                  quot, dnorm;
  logic [LW-1:0]                  cls_len_q;
  logic [dtwgtc_pkg::IDX_W-1:0]   best_idx_q;
  logic [dtwgtc_pkg::DIST_W-1:0]  best_dist_q;
  logic                           valid_q;

  always_comb begin
    if (tiu_q == '0) begin
      n_active = dtwgtc_pkg::TCNT_W'(1);
    end else if (32'(tiu_q) > dtwgtc_pkg::TEMPLATE_COUNT) begin
      n_active = dtwgtc_pkg::TCNT_W'(dtwgtc_pkg::TEMPLATE_COUNT);
    end else begin
      n_active = dtwgtc_pkg::TCNT_W'(tiu_q);
    end
  end

  assign cur_len   = len_q[cmd_i.t];
  assign base_addr = AW'(AW'(cmd_i.t) * AW'(dtwgtc_pkg::TEMPLATE_MAX_LEN));
  assign row_addr  = AW'(base_addr + AW'(cmd_i.j));
  assign t_we      = cmd_i.load_do && (32'(slot_q) < dtwgtc_pkg::TEMPLATE_COUNT)
                     && (32'(lp_q) < dtwgtc_pkg::TEMPLATE_MAX_LEN);
  assign t_waddr   = AW'(AW'(slot_q) * AW'(dtwgtc_pkg::TEMPLATE_MAX_LEN) + AW'(lp_q));
  assign c_raddr   = cmd_i.cls_rd ? AW'(base_addr + AW'(cur_len) - AW'(1)) : row_addr;

  dtwgtc_ram #(.Width(dtwgtc_pkg::TSW_W), .Depth(dtwgtc_pkg::STORE_DEPTH)) u_tmpl (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i ({gz_q, gy_q, gx_q}),
    .raddr_i (row_addr),
    .rdata_o (t_rdata)
  );

  dtwgtc_ram #(.Width(CW), .Depth(dtwgtc_pkg::STORE_DEPTH)) u_cost (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (s2_addr_q),
    .wdata_i (cell_val),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  // local cost: squared euclidean distance
  always_comb begin
    dx  = (SW+1)'(gx_q) - (SW+1)'($signed(t_rdata[SW-1:0]));
    dy  = (SW+1)'(gy_q) - (SW+1)'($signed(t_rdata[2*SW-1:SW]));
    dz  = (SW+1)'(gz_q) - (SW+1)'($signed(t_rdata[3*SW-1:2*SW]));
    sqx = (2*SW+2)'(dx * dx);
    sqy = (2*SW+2)'(dy * dy);
    sqz = (2*SW+2)'(dz * dz);
    lc  = dtwgtc_pkg::LC_W'(sqx) + dtwgtc_pkg::LC_W'(sqy) + dtwgtc_pkg::LC_W'(sqz);
  end

  always_comb begin
    row0 = (gc_q == '0);
    m1   = (left_q < s2_up_q) ? left_q : s2_up_q;
    if (row0 && s2_first_q) begin
      prior = '0;
    end else if (row0) begin
      prior = left_q;
    end else if (s2_first_q) begin
      prior = s2_up_q;
    end else begin
      prior = (m1 < diag_q) ? m1 : diag_q;
    end
    cell_sum = {1'b0, prior} + (CW+1)'(s2_lc_q);
    cell_val = cell_sum[CW] ? '1 : cell_sum[CW-1:0];
  end

  assign c_we = s2_v_q;

  // normalization
  assign glen     = (gc_q == '0) ? dtwgtc_pkg::GC_W'(1) : gc_q;
  assign dividend = (cls_len_q == '0) ? dtwgtc_pkg::EMPTY_SCORE : c_rdata;
  assign divisor  = dtwgtc_pkg::DIV_W'(glen) + dtwgtc_pkg::DIV_W'(cls_len_q);
  assign dnorm    = (quot > dtwgtc_pkg::EMPTY_SCORE) ? dtwgtc_pkg::EMPTY_SCORE : quot;

  dtwgtc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tiu_q   <= dtwgtc_pkg::CFG_W'(8);
      lp_q    <= '0;
      gc_q    <= '0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      valid_q <= 1'b0;
      op_q    <= 1'b0;
      last_q  <= 1'b0;
      for (int i = 0; i < dtwgtc_pkg::TEMPLATE_COUNT; i++) begin
        len_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        tiu_q <= cfg_data_i;
      end
      if (cmd_i.capture) begin
        op_q   <= op_i;
        last_q <= last_sample_i;
      end
      if (cmd_i.load_do && (32'(slot_q) < dtwgtc_pkg::TEMPLATE_COUNT)) begin
        if (last_q) begin
          len_q[slot_q[dtwgtc_pkg::T_W-1:0]] <= t_we ? LW'(lp_q + LW'(1)) : lp_q;
          lp_q <= '0;
        end else if (t_we) begin
          lp_q <= LW'(lp_q + LW'(1));
        end
      end
      if (cmd_i.gc_step && !(32'(gc_q) >= dtwgtc_pkg::GESTURE_MAX_LEN)) begin
        gc_q <= dtwgtc_pkg::GC_W'(gc_q + dtwgtc_pkg::GC_W'(1));
      end else if (cmd_i.out_fire) begin
        gc_q <= '0;
      end
      s1_v_q  <= cmd_i.row_issue;
      s2_v_q  <= s1_v_q;
      valid_q <= cmd_i.out_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      slot_q <= template_slot_i;
      gx_q   <= accel_x_i;
      gy_q   <= accel_y_i;
      gz_q   <= accel_z_i;
    end
    s1_addr_q  <= row_addr;
    s1_first_q <= (cmd_i.j == '0);
    s2_addr_q  <= s1_addr_q;
    s2_first_q <= s1_first_q;
    s2_lc_q    <= lc;
    s2_up_q    <= c_rdata;
    if (s2_v_q) begin
      left_q <= cell_val;
      diag_q <= s2_up_q;
    end
    if (cmd_i.cls_rd) begin
      cls_len_q <= cur_len;
    end
    if (cmd_i.cls_take && ((cmd_i.t == '0) || (dnorm < CW'(best_dist_q)))) begin
      best_idx_q  <= dtwgtc_pkg::IDX_W'(cmd_i.t);
      best_dist_q <= dtwgtc_pkg::DIST_W'(dnorm);
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.op        = op_q;
    sts_o.last      = last_q;
    sts_o.gc_full   = (32'(gc_q) >= dtwgtc_pkg::GESTURE_MAX_LEN);
    sts_o.pipe_busy = s1_v_q || s2_v_q;
    sts_o.div_done  = div_done;
    sts_o.cur_len   = cur_len;
    sts_o.n_active  = n_active;
  end

  assign result_valid_o   = valid_q;
  assign match_index_o    = best_idx_q;
  assign match_distance_o = best_dist_q;

endmodule

// ===== tb/tb_dtw_gesture_template_classifier.sv =====
// ----------------------------------------------------------------------------
// tb_dtw_gesture_template_classifier
// Self-checking testbench for the DTW nearest-template gesture classifier.
// Loads templates, streams gestures in bursts with random gaps, predicts each
// classification with a local DTW model and checks every result word in order.
// The slot count register is changed between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_dtw_gesture_template_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   SAMPLE_WIDTH     = dtwgtc_pkg::SAMPLE_WIDTH;
  localparam int   TEMPLATE_COUNT   = dtwgtc_pkg::TEMPLATE_COUNT;
  localparam int   TEMPLATE_MAX_LEN = dtwgtc_pkg::TEMPLATE_MAX_LEN;
  localparam int   GESTURE_MAX_LEN  = dtwgtc_pkg::GESTURE_MAX_LEN;
  localparam int   STORE_DEPTH      = dtwgtc_pkg::STORE_DEPTH;
  localparam int   IDX_W            = dtwgtc_pkg::IDX_W;
  localparam int   DIST_W           = dtwgtc_pkg::DIST_W;
  localparam int   CFG_W            = dtwgtc_pkg::CFG_W;
  localparam logic OP_LOAD          = dtwgtc_pkg::OP_LOAD;
  localparam logic OP_GESTURE       = dtwgtc_pkg::OP_GESTURE;

  localparam int IDLE_LIMIT = 5000;

  typedef struct {
    logic                    op;
    logic [2:0]              slot;
    logic [SAMPLE_WIDTH-1:0] ax;
    logic [SAMPLE_WIDTH-1:0] ay;
    logic [SAMPLE_WIDTH-1:0] az;
    logic                    last;
  } sample_t;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] distance;
  } match_t;

  logic clk_i, rst_ni;
  logic start, busy;
  logic cfg_valid_i, cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i;
  logic op_i, last_sample_i;
  logic [2:0] template_slot_i;
  logic signed [SAMPLE_WIDTH-1:0] accel_x_i, accel_y_i, accel_z_i;
  logic result_valid_o;
  logic [IDX_W-1:0] match_index_o;
  logic [DIST_W-1:0] match_distance_o;

  dtw_gesture_template_classifier DUT (.*);

  // local copy of the classifier state
  int          tmpl_axis [STORE_DEPTH][3];
  int unsigned tmpl_len [TEMPLATE_COUNT];
  int unsigned load_ptr;
  bit [31:0]   dtw_cell [STORE_DEPTH];
  int unsigned gest_cnt;
  int unsigned slots_cfg;

  sample_t pending_q[$];
  match_t  match_q[$];
  int      mismatches;
  int      idle_cycles;
  int      gap_left, burst_left;
  int      item_total;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int sx(logic [SAMPLE_WIDTH-1:0] v);
    return int'($signed(v));
  endfunction

  function automatic int unsigned n_slots();
    int unsigned n;
    n = slots_cfg;
    if (n == 0) n = 1;
    if (n > TEMPLATE_COUNT) n = TEMPLATE_COUNT;
    return n;
  endfunction

  function automatic void dtw_row(int g[3], int unsigned row);
    int unsigned base, len, left, diag, up, prior;
    longint lc, s;
    for (int t = 0; t < n_slots(); t++) begin
      len = tmpl_len[t];
      base = t * TEMPLATE_MAX_LEN;
      left = 0;
      diag = 0;
      for (int j = 0; j < len; j++) begin
        up = dtw_cell[base + j];
        if (row == 0 && j == 0) prior = 0;
        else if (row == 0) prior = left;
        else if (j == 0) prior = up;
        else begin
          prior = (left < up) ? left : up;
          if (diag < prior) prior = diag;
        end
        lc = 0;
        for (int k = 0; k < 3; k++)
          lc += longint'(g[k] - tmpl_axis[base + j][k]) * (g[k] - tmpl_axis[base + j][k]);
        s = longint'(prior) + lc;
        if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
        diag = up;
        left = s[31:0];
        dtw_cell[base + j] = s[31:0];
      end
    end
  endfunction

  function automatic match_t nearest_template();
    match_t m;
    int unsigned glen, len;
    longint unsigned total, d, best_d;
    int unsigned best;
    glen = (gest_cnt == 0) ? 1 : gest_cnt;
    best = 0;
    best_d = 0;
    for (int t = 0; t < n_slots(); t++) begin
      len = tmpl_len[t];
      total = (len == 0) ? 100000000 : dtw_cell[t * TEMPLATE_MAX_LEN + len - 1];
      d = total / (glen + len);
      if (d > 100000000) d = 100000000;
      if (t == 0 || d < best_d) begin
        best = t;
        best_d = d;
      end
    end
    m.idx = best[IDX_W-1:0];
    m.distance = best_d[DIST_W-1:0];
    return m;
  endfunction

  function automatic void apply_sample(sample_t s);
    int g[3];
    int unsigned a;
    g[0] = sx(s.ax);
    g[1] = sx(s.ay);
    g[2] = sx(s.az);
    if (s.op == OP_LOAD) begin
      if (load_ptr < TEMPLATE_MAX_LEN) begin
        a = s.slot * TEMPLATE_MAX_LEN + load_ptr;
        for (int k = 0; k < 3; k++) tmpl_axis[a][k] = g[k];
        load_ptr++;
      end
      if (s.last) begin
        tmpl_len[s.slot] = load_ptr;
        load_ptr = 0;
      end
    end else begin
      if (gest_cnt < GESTURE_MAX_LEN) begin
        dtw_row(g, gest_cnt);
        gest_cnt++;
      end
      if (s.last) begin
        match_q.push_back(nearest_template());
        gest_cnt = 0;
      end
    end
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    logic go;
    sample_t nx;
    if (!rst_ni) begin
      start <= 1'b0;
      op_i <= 1'b0;
      template_slot_i <= '0;
      accel_x_i <= '0;
      accel_y_i <= '0;
      accel_z_i <= '0;
      last_sample_i <= 1'b0;
      gap_left <= 0;
      burst_left <= 4;
    end else begin
      if (start && !busy)
        apply_sample(pending_q.pop_front());
      if (!(start && busy)) begin
        go = 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
        else if (pending_q.size() > 0) begin
          go = 1'b1;
          nx = pending_q[0];
          op_i <= nx.op;
          template_slot_i <= nx.slot;
          accel_x_i <= nx.ax;
          accel_y_i <= nx.ay;
          accel_z_i <= nx.az;
          last_sample_i <= nx.last;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
          end else burst_left <= burst_left - 1;
        end
        start <= go;
      end
    end
  end

  // monitor, register shadow, watchdog
  always @(posedge clk_i) begin
    match_t e;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) slots_cfg = 32'(cfg_data_i);
      if (result_valid_o) begin
        if (match_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result idx=%0d dist=%0d", match_index_o, match_distance_o);
        end else begin
          e = match_q.pop_front();
          if (e.idx !== match_index_o || e.distance !== match_distance_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp idx=%0d dist=%0d got idx=%0d dist=%0d",
                       e.idx, e.distance, match_index_o, match_distance_o);
          end
        end
      end
      if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic [SAMPLE_WIDTH-1:0] rnd_axis();
    case ($urandom_range(0, 7))
      0: return 8'h7F;
      1: return 8'h80;
      default: return SAMPLE_WIDTH'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push(logic op, logic [2:0] slot, logic last);
    sample_t s;
    s.op = op;
    s.slot = slot;
    s.ax = rnd_axis();
    s.ay = rnd_axis();
    s.az = rnd_axis();
    s.last = last;
    pending_q.push_back(s);
    item_total++;
  endtask

  task automatic add_template(logic [2:0] slot, int n);
    for (int i = 0; i < n; i++) push(OP_LOAD, slot, i == n - 1);
  endtask

  task automatic add_gesture(int n);
    for (int i = 0; i < n; i++) push(OP_GESTURE, 3'd0, i == n - 1);
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || start || busy || match_q.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_slots(logic [CFG_W-1:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i);
    while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned glen;
    load_ptr = 0;
    gest_cnt = 0;
    slots_cfg = 8;
    mismatches = 0;
    idle_cycles = 0;
    item_total = 0;
    foreach (tmpl_len[i]) tmpl_len[i] = 0;
    foreach (dtw_cell[i]) dtw_cell[i] = 0;
    foreach (tmpl_axis[i, k]) tmpl_axis[i][k] = 0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all slots empty, then short templates and gestures, single samples included
    add_gesture(2);
    add_template(3'd0, 1);
    add_template(3'd7, 3);
    add_gesture(1);
    add_template(3'd2, 4);
    add_gesture(4);
    write_slots(4'd1);
    add_gesture(3);
    write_slots(4'd0);
    add_gesture(2);
    write_slots(4'd15);
    add_gesture(2);

    // overlong template: samples past the slot depth are dropped
    add_template(3'd5, TEMPLATE_MAX_LEN + 3);
    add_template(3'd1, TEMPLATE_MAX_LEN);
    add_gesture(3);
    // overlong gesture with small templates: tail dropped, last still classifies
    write_slots(4'd8);
    for (int s = 0; s < TEMPLATE_COUNT; s++) add_template(s[2:0], $urandom_range(1, 3));
    add_gesture(GESTURE_MAX_LEN + 3);
    write_slots(4'd3);

    while (item_total < 1170) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 4))
          0: write_slots(4'd1);
          1: write_slots(4'd8);
          2: write_slots(4'd0);
          3: write_slots(4'd15);
          default: write_slots(CFG_W'($urandom_range(0, 15)));
        endcase
      end
      repeat ($urandom_range(0, 3))
        add_template(3'($urandom_range(0, 7)),
                     ($urandom_range(0, 15) == 0) ? $urandom_range(40, 70)
                                                  : $urandom_range(1, 8));
      glen = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
      add_gesture(glen);
      drain();
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
src/dtwgtc_pkg.sv
src/dtwgtc_ram.sv
src/dtwgtc_div.sv
src/dtwgtc_ctrl.sv
src/dtwgtc_dp.sv
src/dtw_gesture_template_classifier.sv
tb/tb_dtw_gesture_template_classifier.sv
